@@ rtl/wcs_pkg.sv @@
package wcs_pkg;

  // Fixed field widths.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int PERP_BITS  = 24;
  localparam int WX_BITS    = 16;
  localparam int H_BITS     = 16;
  localparam int TEX_BITS   = COORD_BITS + 1;
  localparam int TPOS_BITS  = COORD_BITS + FRAC_BITS;
  localparam int DIFF_BITS  = H_BITS + 1;
  localparam int ROW_BITS   = H_BITS + 2;
  localparam int CFG_BITS   = 13;

  // Divider pipelines: quotient bits resolved per register stage.
  localparam int STEPS_PER_STAGE = 4;
  localparam int HDIV_STEPS      = FRAC_BITS;
  localparam int HDIV_STAGES     = (HDIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int SDIV_STEPS      = TPOS_BITS + 1;
  localparam int SDIV_STAGES     = (SDIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam logic [H_BITS-1:0]    LINE_H_MAX = {H_BITS{1'b1}};
  localparam logic [TPOS_BITS-1:0] TPOS_MAX   = {TPOS_BITS{1'b1}};
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam logic [TEX_BITS-1:0]  TEX_MAX    = TEX_BITS'(1) << COORD_BITS;

  typedef enum logic [2:0] {
    CFG_SCREEN_HEIGHT = 3'd0,
    CFG_VIEW_OFFSET   = 3'd1,
    CFG_TEX_WIDTH     = 3'd2,
    CFG_TEX_HEIGHT    = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FACE_SOUTH = 2'd0,
    FACE_NORTH = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_EAST  = 2'd3
  } face_t;

  localparam logic [1:0] DIR_NEG = 2'd0;

  // Fields that ride along the pipeline untouched after the first stage.
  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    face_t                 face;
    logic [COORD_BITS-1:0] tex_col;
  } side_t;

  // Span results carried through the step divider.
  typedef struct packed {
    side_t                 side;
    logic [COORD_BITS-1:0] row_start;
    logic [COORD_BITS-1:0] row_end;
    logic [DIFF_BITS-1:0]  diff;
    logic                  h_zero;
  } span_t;

  // Clamp a texture size register to 1..2^COORD_BITS.
  function automatic logic [TEX_BITS-1:0] tex_size(input logic [TEX_BITS-1:0] v);
    logic [TEX_BITS-1:0] r;
    r = v;
    if (v == '0) r = TEX_BITS'(1);
    else if (v > TEX_MAX) r = TEX_MAX;
    return r;
  endfunction

endpackage

@@ rtl/wcs_hdiv.sv @@
module wcs_hdiv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  wcs_pkg::side_t                  in_side,
  input  logic [wcs_pkg::PERP_BITS-1:0]   in_perp,
  input  logic                            in_sat,
  input  logic [wcs_pkg::COORD_BITS-1:0]  scr_h,
  output logic                            out_valid,
  output wcs_pkg::side_t                  out_side,
  output logic [wcs_pkg::H_BITS-1:0]      out_h
);

  localparam int N  = wcs_pkg::HDIV_STAGES;
  localparam int PB = wcs_pkg::PERP_BITS;
  localparam int HB = wcs_pkg::H_BITS;

  logic                 v_r    [N];
  wcs_pkg::side_t       side_r [N];
  logic [PB-1:0]        perp_r [N];
  logic                 sat_r  [N];
  logic [PB-1:0]        rem_r  [N];
  logic [HB-1:0]        q_r    [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic                 v_in;
    wcs_pkg::side_t       side_in;
    logic [PB-1:0]        perp_in;
    logic                 sat_in;
    logic [PB-1:0]        rem_in;
    logic [HB-1:0]        q_in;
    logic [PB-1:0]        rem_nxt;
    logic [HB-1:0]        q_nxt;

    if (g == 0) begin : g_first
      // Not saturated means screen_height < perp, so the upper quotient
      // bits are zero and the remainder starts as the height itself.
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign perp_in = in_perp;
      assign sat_in  = in_sat;
      assign rem_in  = PB'(scr_h);
      assign q_in    = '0;
    end else begin : g_next
      assign v_in    = v_r[g-1];
      assign side_in = side_r[g-1];
      assign perp_in = perp_r[g-1];
      assign sat_in  = sat_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign q_in    = q_r[g-1];
    end

    // Restoring division, a few quotient bits per stage.
    always_comb begin
      logic [PB:0] t;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int k = 0; k < wcs_pkg::STEPS_PER_STAGE; k++) begin
        if (g * wcs_pkg::STEPS_PER_STAGE + k < wcs_pkg::HDIV_STEPS) begin
          t = {rem_nxt, 1'b0};
          if (t >= {1'b0, perp_in}) begin
            rem_nxt = PB'(t - {1'b0, perp_in});
            q_nxt   = {q_nxt[HB-2:0], 1'b1};
          end else begin
            rem_nxt = t[PB-1:0];
            q_nxt   = {q_nxt[HB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g] <= side_in;
        perp_r[g] <= perp_in;
        sat_r[g]  <= sat_in;
        rem_r[g]  <= rem_nxt;
        q_r[g]    <= q_nxt;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_side  = side_r[N-1];
  assign out_h     = sat_r[N-1] ? wcs_pkg::LINE_H_MAX : q_r[N-1];

endmodule

@@ rtl/wcs_span.sv @@
module wcs_span (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  wcs_pkg::side_t                  in_side,
  input  logic [wcs_pkg::H_BITS-1:0]      in_h,
  input  logic [wcs_pkg::COORD_BITS-1:0]  scr_h,
  input  logic [wcs_pkg::COORD_BITS-1:0]  view_offset,
  output logic                            out_valid,
  output wcs_pkg::span_t                  out_span,
  output logic [wcs_pkg::H_BITS-1:0]      out_h
);

  localparam int RB = wcs_pkg::ROW_BITS;
  localparam int CB = wcs_pkg::COORD_BITS;

  logic signed [RB-1:0] centre;
  logic signed [RB-1:0] half;
  logic signed [RB-1:0] s_raw;
  logic signed [RB-1:0] e_raw;
  logic signed [RB-1:0] e_lim;
  logic signed [RB-1:0] height;
  logic signed [RB-1:0] diff_full;
  logic [CB-1:0]        s_clamp;
  logic [CB-1:0]        e_clamp;
  wcs_pkg::span_t       span_nxt;

  logic           v_r;
  wcs_pkg::span_t span_r;
  logic [wcs_pkg::H_BITS-1:0] h_r;

  // Centered span around the horizon, then clamped to the screen.
  always_comb begin
    height    = $signed(RB'(scr_h));
    centre    = $signed(RB'(scr_h[CB-1:1])) +
                $signed({{(RB-CB){view_offset[CB-1]}}, view_offset});
    half      = $signed(RB'(in_h[wcs_pkg::H_BITS-1:1]));
    s_raw     = centre - half;
    e_raw     = centre + half;
    e_lim     = (e_raw >= height) ? height - RB'(1) : e_raw;

    if (s_raw < 0) s_clamp = '0;
    else if (s_raw > $signed(RB'(wcs_pkg::COORD_MAX))) s_clamp = wcs_pkg::COORD_MAX;
    else s_clamp = s_raw[CB-1:0];

    if (e_lim < 0) e_clamp = '0;
    else if (e_lim > $signed(RB'(wcs_pkg::COORD_MAX))) e_clamp = wcs_pkg::COORD_MAX;
    else e_clamp = e_lim[CB-1:0];

    diff_full = $signed(RB'(s_clamp)) - s_raw;

    span_nxt.side      = in_side;
    span_nxt.row_start = s_clamp;
    span_nxt.row_end   = e_clamp;
    span_nxt.diff      = diff_full[RB-1] ? '0 : diff_full[wcs_pkg::DIFF_BITS-1:0];
    span_nxt.h_zero    = (in_h == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span_r <= span_nxt;
      h_r    <= in_h;
    end
  end

  assign out_valid = v_r;
  assign out_span  = span_r;
  assign out_h     = h_r;

endmodule

@@ rtl/wcs_sdiv.sv @@
module wcs_sdiv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  wcs_pkg::span_t                  in_span,
  input  logic [wcs_pkg::H_BITS-1:0]      in_h,
  input  logic [wcs_pkg::TEX_BITS-1:0]    tex_h,
  output logic                            out_valid,
  output wcs_pkg::span_t                  out_span,
  output logic [wcs_pkg::TPOS_BITS-1:0]   out_step
);

  localparam int N  = wcs_pkg::SDIV_STAGES;
  localparam int HB = wcs_pkg::H_BITS;
  localparam int QB = wcs_pkg::SDIV_STEPS;

  logic [QB-1:0] dvd;

  logic           v_r    [N];
  wcs_pkg::span_t span_r [N];
  logic [HB-1:0]  h_r    [N];
  logic [HB-1:0]  rem_r  [N];
  logic [QB-1:0]  q_r    [N];

  // Dividend is the texture height in fixed point.
  assign dvd = {tex_h, {wcs_pkg::FRAC_BITS{1'b0}}};

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic           v_in;
    wcs_pkg::span_t span_in;
    logic [HB-1:0]  h_in;
    logic [HB-1:0]  rem_in;
    logic [QB-1:0]  q_in;
    logic [HB-1:0]  rem_nxt;
    logic [QB-1:0]  q_nxt;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign span_in = in_span;
      assign h_in    = in_h;
      assign rem_in  = '0;
      assign q_in    = '0;
    end else begin : g_next
      assign v_in    = v_r[g-1];
      assign span_in = span_r[g-1];
      assign h_in    = h_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign q_in    = q_r[g-1];
    end

    // Restoring division, dividend bits fed in from the top.
    always_comb begin
      logic [HB:0] t;
      int          idx;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int k = 0; k < wcs_pkg::STEPS_PER_STAGE; k++) begin
        idx = QB - 1 - (g * wcs_pkg::STEPS_PER_STAGE + k);
        if (idx >= 0) begin
          t = {rem_nxt, dvd[idx]};
          if (t >= {1'b0, h_in}) begin
            rem_nxt = HB'(t - {1'b0, h_in});
            q_nxt   = {q_nxt[QB-2:0], 1'b1};
          end else begin
            rem_nxt = t[HB-1:0];
            q_nxt   = {q_nxt[QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        span_r[g] <= span_in;
        h_r[g]    <= h_in;
        rem_r[g]  <= rem_nxt;
        q_r[g]    <= q_nxt;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_span  = span_r[N-1];

  // Zero height gives a zero step; an overflowing quotient saturates.
  always_comb begin
    if (span_r[N-1].h_zero) out_step = '0;
    else if (q_r[N-1][QB-1]) out_step = wcs_pkg::TPOS_MAX;
    else out_step = q_r[N-1][wcs_pkg::TPOS_BITS-1:0];
  end

endmodule

@@ rtl/wall_column_span_setup.sv @@
// Wall column span setup: takes one ray hit per word and returns one span
// descriptor per word (rows to draw, texture face and column, starting
// texture row and per-row step). A new word is accepted every cycle while
// the output side takes results. A result passes through 16 register
// stages once its word is accepted: the input stage, four
// line-height divider stages, the row span stage, eight texture-step divider
// stages, the start-row product stage and the output register. Each divider
// resolves four quotient bits per register stage. A stall on the output
// holds every stage. Configuration registers are read live and should be
// written only while no word is in flight.
module wall_column_span_setup (
  input  logic          clk,
  input  logic          rst_n,
  // column[11:0], perp_dist[35:12], wall_x[51:36], zero pad[55:52]
  input  logic [55:0]   in_tdata,
  // side[0], dir_sign[2:1]
  input  logic [2:0]    in_tuser,
  input  logic          in_tvalid,
  output logic          in_tready,
  // out_column[11:0], row_start[23:12], row_end[35:24], tex_col[47:36],
  // tex_row_start[75:48], tex_row_step[103:76]
  output logic [103:0]  out_tdata,
  // face[1:0]
  output logic [1:0]    out_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [12:0]   cfg_wdata
);

  localparam int CB = wcs_pkg::COORD_BITS;
  localparam int TB = wcs_pkg::TEX_BITS;
  localparam int PB = wcs_pkg::PERP_BITS;
  localparam int PRODB = wcs_pkg::DIFF_BITS + wcs_pkg::TPOS_BITS;

  logic [CB-1:0] screen_height_r;
  logic [CB-1:0] view_offset_r;
  logic [TB-1:0] tex_width_r;
  logic [TB-1:0] tex_height_r;
  logic [TB-1:0] tw_eff;
  logic [TB-1:0] th_eff;

  logic en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= CB'(480);
      view_offset_r   <= '0;
      tex_width_r     <= TB'(64);
      tex_height_r    <= TB'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcs_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[CB-1:0];
        wcs_pkg::CFG_VIEW_OFFSET:   view_offset_r   <= cfg_wdata[CB-1:0];
        wcs_pkg::CFG_TEX_WIDTH:     tex_width_r     <= cfg_wdata;
        wcs_pkg::CFG_TEX_HEIGHT:    tex_height_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign tw_eff = wcs_pkg::tex_size(tex_width_r);
  assign th_eff = wcs_pkg::tex_size(tex_height_r);

  // The whole pipeline advances when the output register is free.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Input stage: face, texture column and line-height saturation check.
  logic [CB-1:0]      in_column;
  logic [PB-1:0]      in_perp;
  logic [15:0]        in_wx;
  logic               in_side;
  logic [1:0]         in_dir;
  logic               dir_pos;
  logic [PB-1:0]      perp_nz;
  logic [TB+15:0]     tc_prod;
  logic [TB-1:0]      tc_raw;
  logic [TB-1:0]      tc_clamp;
  logic [TB-1:0]      tc_final;
  wcs_pkg::side_t     side_nxt;

  assign in_column = in_tdata[11:0];
  assign in_perp   = in_tdata[35:12];
  assign in_wx     = in_tdata[51:36];
  assign in_side   = in_tuser[0];
  assign in_dir    = in_tuser[2:1];
  assign dir_pos   = in_dir[1];

  always_comb begin
    perp_nz  = (in_perp == '0) ? PB'(1) : in_perp;
    tc_prod  = in_wx * tw_eff;
    tc_raw   = tc_prod[TB+15:16];
    tc_clamp = (tc_raw >= tw_eff) ? tw_eff - TB'(1) : tc_raw;
    if ((!in_side && in_dir == wcs_pkg::DIR_NEG) || (in_side && dir_pos))
      tc_final = tw_eff - TB'(1) - tc_clamp;
    else
      tc_final = tc_clamp;

    side_nxt.column  = in_column;
    side_nxt.tex_col = tc_final[CB-1:0];
    if (in_side) side_nxt.face = dir_pos ? wcs_pkg::FACE_SOUTH : wcs_pkg::FACE_NORTH;
    else         side_nxt.face = dir_pos ? wcs_pkg::FACE_WEST  : wcs_pkg::FACE_EAST;
  end

  logic           s0_valid_r;
  wcs_pkg::side_t s0_side_r;
  logic [PB-1:0]  s0_perp_r;
  logic           s0_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= side_nxt;
      s0_perp_r <= perp_nz;
      s0_sat_r  <= (perp_nz <= PB'(screen_height_r));
    end
  end

  // Line height divider.
  logic                       hd_valid;
  wcs_pkg::side_t             hd_side;
  logic [wcs_pkg::H_BITS-1:0] hd_h;

  wcs_hdiv u_hdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_valid_r),
    .in_side   (s0_side_r),
    .in_perp   (s0_perp_r),
    .in_sat    (s0_sat_r),
    .scr_h     (screen_height_r),
    .out_valid (hd_valid),
    .out_side  (hd_side),
    .out_h     (hd_h)
  );

  // Row span.
  logic                       sp_valid;
  wcs_pkg::span_t             sp_span;
  logic [wcs_pkg::H_BITS-1:0] sp_h;

  wcs_span u_span (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (hd_valid),
    .in_side     (hd_side),
    .in_h        (hd_h),
    .scr_h       (screen_height_r),
    .view_offset (view_offset_r),
    .out_valid   (sp_valid),
    .out_span    (sp_span),
    .out_h       (sp_h)
  );

  // Texture step divider.
  logic                          sd_valid;
  wcs_pkg::span_t                sd_span;
  logic [wcs_pkg::TPOS_BITS-1:0] sd_step;

  wcs_sdiv u_sdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sp_valid),
    .in_span   (sp_span),
    .in_h      (sp_h),
    .tex_h     (th_eff),
    .out_valid (sd_valid),
    .out_span  (sd_span),
    .out_step  (sd_step)
  );

  // Texture start row product.
  logic                          mul_valid_r;
  wcs_pkg::span_t                mul_span_r;
  logic [wcs_pkg::TPOS_BITS-1:0] mul_step_r;
  logic [PRODB-1:0]              mul_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (en) begin
      mul_valid_r <= sd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_span_r <= sd_span;
      mul_step_r <= sd_step;
      mul_prod_r <= sd_span.diff * sd_step;
    end
  end

  // Output register with start row saturation.
  logic                          out_valid_r;
  wcs_pkg::span_t                out_span_r;
  logic [wcs_pkg::TPOS_BITS-1:0] out_step_r;
  logic [wcs_pkg::TPOS_BITS-1:0] out_tpos_r;
  logic [wcs_pkg::TPOS_BITS-1:0] tpos_nxt;

  always_comb begin
    if (mul_span_r.h_zero) tpos_nxt = '0;
    else if (|mul_prod_r[PRODB-1:wcs_pkg::TPOS_BITS]) tpos_nxt = wcs_pkg::TPOS_MAX;
    else tpos_nxt = mul_prod_r[wcs_pkg::TPOS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_span_r <= mul_span_r;
      out_step_r <= mul_step_r;
      out_tpos_r <= tpos_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_span_r.side.face;
  assign out_tdata  = {out_step_r, out_tpos_r, out_span_r.side.tex_col,
                       out_span_r.row_end, out_span_r.row_start,
                       out_span_r.side.column};

  // A zero step only comes from a zero line height, which forces a zero start.
  a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_step_r == '0 |-> out_tpos_r == '0)
    else $error("zero texture step with nonzero start row");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !mul_valid_r && !s0_valid_r)
    else $error("valid bit set after reset");

  // A held pipeline keeps its words in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(mul_valid_r) && $stable(mul_prod_r) && $stable(s0_valid_r))
    else $error("pipeline moved during a stall");

endmodule

@@ bench/wcs_span_checker.sv @@
module wcs_span_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [55:0]  in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [12:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [11:0]    column;
    logic [11:0]    row_start;
    logic [11:0]    row_end;
    wcs_pkg::face_t face;
    logic [11:0]    tex_col;
    logic [27:0]    tex_row_start;
    logic [27:0]    tex_row_step;
  } span_desc_t;

  // Shadow copy of the configuration registers.
  logic [11:0]        screen_height;
  logic signed [11:0] view_offset;
  logic [12:0]        tex_width;
  logic [12:0]        tex_height;

  span_desc_t span_q[$];

  function automatic longint clamp_tex(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Computes the span descriptor of one ray hit from the current registers.
  function automatic span_desc_t span_for_hit(input logic [55:0] d, input logic [2:0] u);
    span_desc_t r;
    longint perp, h, half, centre, s_raw, e_raw, s, e, tw, th, tc, step, tpos, diff;
    longint tmax;
    logic is_side, pos, neg;
    tmax = (longint'(1) << 28) - 1;
    perp = d[35:12];
    is_side = u[0];
    pos = u[2:1] >= 2'd2;
    neg = u[2:1] == wcs_pkg::DIR_NEG;
    if (perp == 0) perp = 1;
    h = (longint'(screen_height) << wcs_pkg::FRAC_BITS) / perp;
    if (h > 65535) h = 65535;
    half = h / 2;
    centre = longint'(screen_height) / 2 + longint'(view_offset);
    s_raw = centre - half;
    e_raw = centre + half;
    s = clamp_coord(s_raw);
    e = e_raw;
    if (e >= longint'(screen_height)) e = longint'(screen_height) - 1;
    e = clamp_coord(e);
    if (is_side) r.face = pos ? wcs_pkg::FACE_SOUTH : wcs_pkg::FACE_NORTH;
    else r.face = pos ? wcs_pkg::FACE_WEST : wcs_pkg::FACE_EAST;
    tw = clamp_tex(tex_width);
    th = clamp_tex(tex_height);
    tc = (longint'(d[51:36]) * tw) >> wcs_pkg::FRAC_BITS;
    if (tc >= tw) tc = tw - 1;
    if ((!is_side && neg) || (is_side && pos)) tc = tw - 1 - tc;
    step = 0;
    tpos = 0;
    if (h != 0) begin
      step = (th << wcs_pkg::FRAC_BITS) / h;
      if (step > tmax) step = tmax;
      diff = s - s_raw;
      if (diff < 0) diff = 0;
      tpos = diff * step;
      if (tpos > tmax) tpos = tmax;
    end
    r.column = d[11:0];
    r.row_start = s[11:0];
    r.row_end = e[11:0];
    r.tex_col = tc[11:0];
    r.tex_row_start = tpos[27:0];
    r.tex_row_step = step[27:0];
    return r;
  endfunction

  task automatic check_field(input string name, input longint expd, input longint got);
    if (expd != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, expd, got);
      fail_count++;
    end
  endtask

  assign pending = span_q.size();

  // Register writes, input words and result words, all sampled at the rising edge.
  always @(posedge clk) begin
    span_desc_t exp_span;
    if (!rst_n) begin
      screen_height = 12'd480;
      view_offset = '0;
      tex_width = 13'd64;
      tex_height = 13'd64;
      span_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wcs_pkg::CFG_SCREEN_HEIGHT: screen_height = cfg_wdata[11:0];
          wcs_pkg::CFG_VIEW_OFFSET:   view_offset = cfg_wdata[11:0];
          wcs_pkg::CFG_TEX_WIDTH:     tex_width = cfg_wdata;
          wcs_pkg::CFG_TEX_HEIGHT:    tex_height = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) span_q.push_back(span_for_hit(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (span_q.size() == 0) begin
          $error("result word with no expected span pending");
          fail_count++;
        end else begin
          exp_span = span_q.pop_front();
          check_field("out_column", exp_span.column, out_tdata[11:0]);
          check_field("row_start", exp_span.row_start, out_tdata[23:12]);
          check_field("row_end", exp_span.row_end, out_tdata[35:24]);
          check_field("face", exp_span.face, out_tuser);
          check_field("tex_col", exp_span.tex_col, out_tdata[47:36]);
          check_field("tex_row_start", exp_span.tex_row_start, out_tdata[75:48]);
          check_field("tex_row_step", exp_span.tex_row_step, out_tdata[103:76]);
        end
      end
    end
  end

endmodule

@@ bench/wall_column_span_setup_test.sv @@
module wall_column_span_setup_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int PIPE_LATENCY = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 154;
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd5;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [55:0]  in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [12:0]  cfg_wdata = '0;
  int           fail_count;
  int           pending;
  int           sent_words = 0;
  int           burst_left = 0;
  int           idle_cycles = 0;

  always #1 clk = ~clk;

  wall_column_span_setup dut (.*);

  wcs_span_checker checker_i (.*);

  // Offers one ray hit and waits until it is taken; gaps fall between bursts.
  task automatic send_hit(input logic [11:0] col, input logic [23:0] perp,
                          input logic [15:0] wx, input logic is_side, input logic [1:0] dir);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tdata <= {4'b0, wx, perp, col};
    in_tuser <= {dir, is_side};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sent_words++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [12:0] sh, input logic [12:0] vo,
                            input logic [12:0] tw, input logic [12:0] th);
    write_reg(wcs_pkg::CFG_SCREEN_HEIGHT, sh);
    write_reg(wcs_pkg::CFG_VIEW_OFFSET, vo);
    write_reg(wcs_pkg::CFG_TEX_WIDTH, tw);
    write_reg(wcs_pkg::CFG_TEX_HEIGHT, th);
  endtask

  // Corner hits: distance extremes, hit fraction extremes, every face and direction code.
  task automatic corner_hits();
    send_hit(12'd0, 24'd0, 16'd0, 1'b0, 2'd0);
    send_hit(12'hFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, 2'd2);
    send_hit(12'd1, 24'd1, 16'h8000, 1'b0, 2'd2);
    send_hit(12'd2, 24'h010000, 16'hFFFF, 1'b0, 2'd1);
    send_hit(12'd3, 24'h020000, 16'd1, 1'b1, 2'd0);
    send_hit(12'd4, 24'h008000, 16'h4000, 1'b1, 2'd1);
    send_hit(12'd5, 24'h100000, 16'hC000, 1'b0, 2'd3);
    send_hit(12'd6, 24'h000100, 16'h1234, 1'b1, 2'd3);
    send_hit(12'h800, 24'h7FFFFF, 16'hFFFF, 1'b0, 2'd0);
    send_hit(12'h555, 24'h0000FF, 16'h0001, 1'b1, 2'd2);
    send_hit(12'hAAA, 24'h040000, 16'hAAAA, 1'b0, 2'd2);
  endtask

  // Random distance spread over all magnitudes so both saturated and tiny heights occur.
  task automatic random_hit();
    logic [23:0] perp;
    int mag;
    mag = $urandom_range(0, 24);
    perp = 24'($urandom());
    if (mag < 24) perp = perp & ((24'd1 << mag) - 24'd1);
    send_hit(12'($urandom()), perp, 16'($urandom()), 1'($urandom()),
             2'($urandom_range(0, 3)));
  endtask

  function automatic logic [12:0] pick_tex();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'($urandom_range(4097, 8191));
      2: return 13'd4096;
      3: return 13'd1;
      default: return 13'($urandom_range(1, 256));
    endcase
  endfunction

  // Receiver: changing ready patterns, plus one long hold-off once traffic runs.
  initial begin
    int mode, mode_left, hold_left;
    logic held;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!held && sent_words >= 400) begin
        held = 1'b1;
        hold_left = 300;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no handshake and no register write.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("wall_column_span_setup regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings first, then the extremes of every register.
    corner_hits();
    drain();
    set_config(13'd1, 13'h800, 13'd1, 13'd1);
    write_reg(CFG_UNUSED_IDX, 13'h1FFF);
    corner_hits();
    drain();
    set_config(13'h0FFF, 13'h7FF, 13'd4096, 13'd4096);
    corner_hits();
    drain();
    set_config(13'd0, 13'd0, 13'd0, 13'h1FFF);
    corner_hits();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(0, 2) == 0)
        set_config(13'($urandom_range(1, 64)), 13'($urandom()), pick_tex(), pick_tex());
      else
        set_config(13'($urandom_range(1, 4095)), 13'($urandom()), pick_tex(), pick_tex());
      for (int i = 0; i < WORDS_PER_PHASE; i++) random_hit();
      drain();
    end

    if (fail_count == 0)
      $display("wall_column_span_setup regression: pass");
    else
      $display("wall_column_span_setup regression: fail");
    $finish;
  end

endmodule
